// ===== rtl/core/tce_pkg.sv =====
package tce_pkg;

    // Field widths fixed by the interface
    localparam int FUNC_W  = 2;
    localparam int CHAR_W  = 8;
    localparam int COL_W   = 7;
    localparam int ROW_W   = 5;
    localparam int COLOR_W = 8;
    localparam int LIN_W   = 11;
    localparam int CELL_W  = 16;

    // Default screen geometry
    localparam int DEF_COLUMNS = 80;
    localparam int DEF_ROWS    = 25;

    // Character codes and reset attribute
    localparam logic [CHAR_W-1:0]  CHAR_NEWLINE   = 8'h0A;
    localparam logic [CHAR_W-1:0]  CHAR_BACKSPACE = 8'h08;
    localparam logic [CHAR_W-1:0]  CHAR_SPACE     = 8'h20;
    localparam logic [COLOR_W-1:0] RESET_COLOR    = 8'h0F;

    // Operation codes
    typedef enum logic [FUNC_W-1:0] {
        FUNC_PUT_CHAR = 2'd0,
        FUNC_PUT_AT   = 2'd1,
        FUNC_CLEAR    = 2'd2,
        FUNC_READ     = 2'd3
    } t_func;

    // Sequencer states
    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_DECODE,
        S_ADDR,
        S_WRITE,
        S_RD_REQ,
        S_RD_WAIT,
        S_SCROLL_RD,
        S_SCROLL_WR,
        S_BLANK,
        S_DONE
    } t_state;

    // Command item
    typedef struct packed {
        t_func               func;
        logic [CHAR_W-1:0]   char_code;
        logic [COL_W-1:0]    col_x;
        logic [ROW_W-1:0]    row_y;
        logic [COLOR_W-1:0]  cell_color;
    } t_cmd;

    // Result item
    typedef struct packed {
        logic [COL_W-1:0]  cursor_col;
        logic [ROW_W-1:0]  cursor_row;
        logic [LIN_W-1:0]  cursor_linear;
        logic [CELL_W-1:0] cell_value;
        logic              did_scroll;
    } t_result;

endpackage

// ===== rtl/core/tce_cell_ram.sv =====
module tce_cell_ram #(
    parameter int DEPTH = tce_pkg::DEF_COLUMNS * tce_pkg::DEF_ROWS,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                        i_clk,
    input  logic                        i_we,
    input  logic [AW-1:0]               i_waddr,
    input  logic [tce_pkg::CELL_W-1:0]  i_wdata,
    input  logic                        i_re,
    input  logic [AW-1:0]               i_raddr,
    output logic [tce_pkg::CELL_W-1:0]  o_rdata
);

    logic [tce_pkg::CELL_W-1:0] r_mem [DEPTH];

    // One write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // One read port, registered data
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

// ===== rtl/core/text_console_engine.sv =====
// Channel   | Direction | Handshake                      | Payload
// ----------+-----------+--------------------------------+---------------------
// command   | in        | start high while busy low      | i_cmd (t_cmd)
// result    | out       | o_done strobe, one cycle       | o_result (t_result)
// colour    | in        | i_cfg_valid and o_cfg_ready    | i_cfg_data (8 bits)
//
// One item at a time through a sequencer around a cell memory with separate
// write and read ports and one row*COLUMNS+col address unit. A write passes
// decode, address, write and done; a read decode, address, read request, read
// wait and done. Newline without scroll, backspace at home and out-of-range
// put-at or read go from decode to done. A scroll, also after a wrapping write,
// copies each cell up a row by a read and a write state, then blanks the bottom
// row. Busy drops in the result cycle. After reset a clearing pass fills the
// screen with 0x0F20 while busy is high; colour writes are taken at any time.
// The receiver cannot stall: a result is on o_result for the single o_done cycle.
module text_console_engine #(
    parameter int COLUMNS = tce_pkg::DEF_COLUMNS,
    parameter int ROWS    = tce_pkg::DEF_ROWS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  tce_pkg::t_cmd                i_cmd,
    output logic                         o_done,
    output tce_pkg::t_result             o_result,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [tce_pkg::COLOR_W-1:0]  i_cfg_data
);

    localparam int CELLS = COLUMNS * ROWS;
    localparam int CW    = $clog2(CELLS);

    localparam logic [tce_pkg::CELL_W-1:0] ResetBlank =
        {tce_pkg::RESET_COLOR, tce_pkg::CHAR_SPACE};

    tce_pkg::t_state               r_state, n_state;
    tce_pkg::t_cmd                 r_cmd, n_cmd;
    logic [tce_pkg::COL_W-1:0]     r_col, n_col;
    logic [tce_pkg::ROW_W-1:0]     r_row, n_row;
    logic [tce_pkg::COL_W-1:0]     r_tgt_col, n_tgt_col;
    logic [tce_pkg::ROW_W-1:0]     r_tgt_row, n_tgt_row;
    logic [tce_pkg::COLOR_W-1:0]   r_color;
    logic [tce_pkg::CELL_W-1:0]    r_wdata, n_wdata;
    logic [tce_pkg::CELL_W-1:0]    r_value, n_value;
    logic [CW-1:0]                 r_ptr, n_ptr;
    logic [CW-1:0]                 r_addr, n_addr;
    logic                          r_rd, n_rd;
    logic                          r_scroll, n_scroll;
    logic                          r_done, n_done;
    tce_pkg::t_result              r_result, n_result;

    // Address unit operands and result
    logic [tce_pkg::COL_W-1:0]     au_col;
    logic [tce_pkg::ROW_W-1:0]     au_row;
    logic [CW-1:0]                 au_sum;

    // Memory port signals
    logic                          ram_we, ram_re;
    logic [CW-1:0]                 ram_waddr, ram_raddr;
    logic [tce_pkg::CELL_W-1:0]    ram_wdata, ram_rdata;

    logic [tce_pkg::CELL_W-1:0]    blank;
    logic                          last_col, last_row, at_home, xy_in_range;

    tce_cell_ram #(
        .DEPTH (CELLS),
        .AW    (CW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Shared address unit: row * COLUMNS + col
    assign au_sum = CW'(CW'(au_row) * CW'(COLUMNS) + CW'(au_col));

    assign blank       = {r_color, tce_pkg::CHAR_SPACE};
    assign last_col    = (int'(r_col) + 1) >= COLUMNS;
    assign last_row    = (int'(r_row) + 1) >= ROWS;
    assign at_home     = (r_col == '0) && (r_row == '0);
    assign xy_in_range = (int'(r_cmd.col_x) < COLUMNS) && (int'(r_cmd.row_y) < ROWS);

    assign busy        = (r_state != tce_pkg::S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_done      = r_done;
    assign o_result    = r_result;

    // Colour register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_color <= tce_pkg::RESET_COLOR;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_color <= i_cfg_data;
        end
    end

    // State and control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= tce_pkg::S_INIT;
            r_col    <= '0;
            r_row    <= '0;
            r_ptr    <= '0;
            r_rd     <= 1'b0;
            r_scroll <= 1'b0;
            r_done   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_col    <= n_col;
            r_row    <= n_row;
            r_ptr    <= n_ptr;
            r_rd     <= n_rd;
            r_scroll <= n_scroll;
            r_done   <= n_done;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_cmd     <= n_cmd;
        r_tgt_col <= n_tgt_col;
        r_tgt_row <= n_tgt_row;
        r_wdata   <= n_wdata;
        r_value   <= n_value;
        r_addr    <= n_addr;
        r_result  <= n_result;
    end

    // Sequencer
    always_comb begin
        n_state   = r_state;
        n_cmd     = r_cmd;
        n_col     = r_col;
        n_row     = r_row;
        n_tgt_col = r_tgt_col;
        n_tgt_row = r_tgt_row;
        n_wdata   = r_wdata;
        n_value   = r_value;
        n_ptr     = r_ptr;
        n_addr    = r_addr;
        n_rd      = r_rd;
        n_scroll  = r_scroll;
        n_done    = 1'b0;
        n_result  = r_result;
        au_col    = r_tgt_col;
        au_row    = r_tgt_row;
        ram_we    = 1'b0;
        ram_waddr = r_ptr;
        ram_wdata = blank;
        ram_re    = 1'b0;
        ram_raddr = r_addr;

        unique case (r_state)
            // Fill the screen with the reset blank after reset
            tce_pkg::S_INIT: begin
                ram_we    = 1'b1;
                ram_wdata = ResetBlank;
                if (r_ptr == CW'(CELLS - 1)) begin
                    n_ptr   = '0;
                    n_state = tce_pkg::S_IDLE;
                end else begin
                    n_ptr = r_ptr + 1'b1;
                end
            end

            tce_pkg::S_IDLE: begin
                if (start) begin
                    n_cmd    = i_cmd;
                    n_scroll = 1'b0;
                    n_value  = '0;
                    n_state  = tce_pkg::S_DECODE;
                end
            end

            // Work out cursor moves and the cell to touch
            tce_pkg::S_DECODE: begin
                n_rd = 1'b0;
                unique case (r_cmd.func)
                    tce_pkg::FUNC_PUT_CHAR: begin
                        if (r_cmd.char_code == tce_pkg::CHAR_NEWLINE) begin
                            n_col = '0;
                            if (last_row) begin
                                n_row    = tce_pkg::ROW_W'(ROWS - 1);
                                n_scroll = 1'b1;
                                n_ptr    = '0;
                                n_state  = tce_pkg::S_SCROLL_RD;
                            end else begin
                                n_row   = r_row + 1'b1;
                                n_state = tce_pkg::S_DONE;
                            end
                        end else if (r_cmd.char_code == tce_pkg::CHAR_BACKSPACE) begin
                            if (at_home) begin
                                n_state = tce_pkg::S_DONE;
                            end else begin
                                if (r_col == '0) begin
                                    n_row = r_row - 1'b1;
                                    n_col = tce_pkg::COL_W'(COLUMNS - 1);
                                end else begin
                                    n_col = r_col - 1'b1;
                                end
                                n_tgt_col = n_col;
                                n_tgt_row = n_row;
                                n_wdata   = blank;
                                n_state   = tce_pkg::S_ADDR;
                            end
                        end else begin
                            n_tgt_col = r_col;
                            n_tgt_row = r_row;
                            n_wdata   = {r_color, r_cmd.char_code};
                            if (last_col) begin
                                n_col = '0;
                                if (last_row) begin
                                    n_row    = tce_pkg::ROW_W'(ROWS - 1);
                                    n_scroll = 1'b1;
                                end else begin
                                    n_row = r_row + 1'b1;
                                end
                            end else begin
                                n_col = r_col + 1'b1;
                            end
                            n_state = tce_pkg::S_ADDR;
                        end
                    end
                    tce_pkg::FUNC_PUT_AT: begin
                        if (xy_in_range) begin
                            n_tgt_col = r_cmd.col_x;
                            n_tgt_row = r_cmd.row_y;
                            n_wdata   = {r_cmd.cell_color, r_cmd.char_code};
                            n_state   = tce_pkg::S_ADDR;
                        end else begin
                            n_state = tce_pkg::S_DONE;
                        end
                    end
                    tce_pkg::FUNC_CLEAR: begin
                        n_col   = '0;
                        n_row   = '0;
                        n_ptr   = '0;
                        n_state = tce_pkg::S_BLANK;
                    end
                    tce_pkg::FUNC_READ: begin
                        if (xy_in_range) begin
                            n_tgt_col = r_cmd.col_x;
                            n_tgt_row = r_cmd.row_y;
                            n_rd      = 1'b1;
                            n_state   = tce_pkg::S_ADDR;
                        end else begin
                            n_state = tce_pkg::S_DONE;
                        end
                    end
                    default: n_state = tce_pkg::S_DONE;
                endcase
            end

            tce_pkg::S_ADDR: begin
                n_addr  = au_sum;
                n_state = r_rd ? tce_pkg::S_RD_REQ : tce_pkg::S_WRITE;
            end

            // Single cell write, then scroll if the cursor ran off the bottom
            tce_pkg::S_WRITE: begin
                ram_we    = 1'b1;
                ram_waddr = r_addr;
                ram_wdata = r_wdata;
                if (r_scroll) begin
                    n_ptr   = '0;
                    n_state = tce_pkg::S_SCROLL_RD;
                end else begin
                    n_state = tce_pkg::S_DONE;
                end
            end

            tce_pkg::S_RD_REQ: begin
                ram_re  = 1'b1;
                n_state = tce_pkg::S_RD_WAIT;
            end

            tce_pkg::S_RD_WAIT: begin
                n_value = ram_rdata;
                n_state = tce_pkg::S_DONE;
            end

            // Scroll: copy cell ptr+COLUMNS down to ptr
            tce_pkg::S_SCROLL_RD: begin
                ram_re    = 1'b1;
                ram_raddr = CW'(r_ptr + CW'(COLUMNS));
                n_state   = tce_pkg::S_SCROLL_WR;
            end

            tce_pkg::S_SCROLL_WR: begin
                ram_we    = 1'b1;
                ram_wdata = ram_rdata;
                n_ptr     = r_ptr + 1'b1;
                if (r_ptr == CW'(CELLS - COLUMNS - 1)) begin
                    n_state = tce_pkg::S_BLANK;
                end else begin
                    n_state = tce_pkg::S_SCROLL_RD;
                end
            end

            // Blank from ptr to the last cell (bottom row or whole screen)
            tce_pkg::S_BLANK: begin
                ram_we = 1'b1;
                if (r_ptr == CW'(CELLS - 1)) begin
                    n_state = tce_pkg::S_DONE;
                end else begin
                    n_ptr = r_ptr + 1'b1;
                end
            end

            // Report the cursor; address unit gives its linear position
            tce_pkg::S_DONE: begin
                au_col                 = r_col;
                au_row                 = r_row;
                n_result.cursor_col    = r_col;
                n_result.cursor_row    = r_row;
                n_result.cursor_linear = tce_pkg::LIN_W'(au_sum);
                n_result.cell_value    = r_value;
                n_result.did_scroll    = r_scroll;
                n_done                 = 1'b1;
                n_state                = tce_pkg::S_IDLE;
            end

            default: n_state = tce_pkg::S_IDLE;
        endcase
    end

endmodule
